/* rtl/core/rtc_pkg.sv */
// Package for the relocation table checker: transaction structs, status codes,
// per-table state record and shared constants. No dependencies.
package rtc_pkg;

	localparam int unsigned OffsetWidth = 33;
	localparam int unsigned CountWidth  = 32;

	// Offset advance for a skip byte, and minimum spacing of relocations
	localparam logic [OffsetWidth-1:0] SkipStep = 33'd254;
	localparam logic [OffsetWidth-1:0] MinGap   = 33'd4;

	// Marker bytes
	localparam logic [7:0] EndMarker = 8'd0;
	localparam logic [7:0] SkipByte  = 8'd1;

	typedef enum logic [2:0] {
		ST_SCAN     = 3'd0,
		ST_DONE     = 3'd1,
		ST_MISALIGN = 3'd2,
		ST_RANGE    = 3'd3,
		ST_TRUNC    = 3'd4,
		ST_ODD      = 3'd5,
		ST_OVERLAP  = 3'd6,
		ST_ZERO     = 3'd7
	} status_t;

	// Input transaction: one byte of the relocation buffer
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_t;

	// Output transaction: status after each byte
	typedef struct packed {
		status_t               status;
		logic [CountWidth-1:0] reloc_count;
		logic [CountWidth-1:0] table_length;
		logic [CountWidth-1:0] overlay_length;
	} out_t;

	// Scan state carried from byte to byte
	typedef struct packed {
		logic [CountWidth-1:0]  byte_position;
		logic [OffsetWidth-1:0] current_offset;
		logic [OffsetWidth-1:0] previous_offset;
		logic [CountWidth-1:0]  count_so_far;
		logic [CountWidth-1:0]  table_bytes;
		logic [CountWidth-1:0]  trailing_bytes;
		status_t                scan_status;
	} table_state_t;

	localparam table_state_t TableStateClear = '{
		byte_position:   '0,
		current_offset:  '0,
		previous_offset: '0,
		count_so_far:    '0,
		table_bytes:     '0,
		trailing_bytes:  '0,
		scan_status:     ST_SCAN
	};

endpackage

/* rtl/core/rtc_step.sv */
// Next-state logic for one relocation table byte: offset assembly, step decode,
// alignment, range and overlap checks. Depends on rtc_pkg.
module rtc_step (
	input  rtc_pkg::table_state_t cur,
	input  rtc_pkg::in_t          item,
	input  logic [31:0]           image_size,
	output rtc_pkg::table_state_t nxt
);
	import rtc_pkg::*;

	function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
		sat_inc = (&v) ? v : v + 1'b1;
	endfunction

	// Alignment first, then image bound, then early end of buffer
	function automatic status_t check_offset(
		input logic [OffsetWidth-1:0] off,
		input logic [31:0]            size,
		input logic                   last
	);
		logic [OffsetWidth:0] top;
		top = {1'b0, off} + {1'b0, MinGap};
		if (off[0])
			check_offset = ST_MISALIGN;
		else if (top > {2'b00, size})
			check_offset = ST_RANGE;
		else if (last)
			check_offset = ST_TRUNC;
		else
			check_offset = ST_SCAN;
	endfunction

	table_state_t           base;
	logic [OffsetWidth-1:0] shifted;
	logic [OffsetWidth-1:0] advanced;
	logic [OffsetWidth-1:0] gap;
	logic [OffsetWidth-1:0] start_off;
	logic                   in_header;

	always_comb begin
		// A first byte restarts the table
		base      = item.first_byte ? TableStateClear : cur;
		in_header = (base.byte_position[CountWidth-1:2] == '0);
		shifted   = {base.current_offset[OffsetWidth-9:0], item.data_byte};
		start_off = {1'b0, shifted[31:0]};
		advanced  = base.current_offset + ((item.data_byte == SkipByte) ? SkipStep :
			{{(OffsetWidth-8){1'b0}}, item.data_byte});
		gap       = advanced - base.previous_offset;
		nxt       = base;

		unique case (base.scan_status)
			ST_DONE: begin
				nxt.trailing_bytes = sat_inc(base.trailing_bytes);
			end
			ST_SCAN: begin
				if (in_header) begin
					// Big-endian start offset, one byte at a time
					nxt.byte_position = base.byte_position + 1'b1;
					if (base.byte_position[1:0] == 2'd3) begin
						nxt.current_offset  = start_off;
						nxt.previous_offset = start_off;
						nxt.count_so_far    = {{(CountWidth-1){1'b0}}, 1'b1};
						if (start_off == '0)
							nxt.scan_status = ST_ZERO;
						else
							nxt.scan_status = check_offset(start_off, image_size,
								item.last_byte);
					end else begin
						nxt.current_offset = shifted;
						if (item.last_byte)
							nxt.scan_status = ST_TRUNC;
					end
				end else begin
					nxt.byte_position = sat_inc(base.byte_position);
					priority if (item.data_byte == EndMarker) begin
						nxt.scan_status = ST_DONE;
						nxt.table_bytes = sat_inc(base.byte_position);
					end else if (item.data_byte == SkipByte) begin
						nxt.current_offset = advanced;
						nxt.scan_status    = check_offset(advanced, image_size,
							item.last_byte);
					end else if (item.data_byte[0]) begin
						nxt.scan_status = ST_ODD;
					end else begin
						nxt.current_offset = advanced;
						if (gap < MinGap) begin
							nxt.scan_status = ST_OVERLAP;
						end else begin
							nxt.previous_offset = advanced;
							nxt.count_so_far    = sat_inc(base.count_so_far);
							nxt.scan_status     = check_offset(advanced, image_size,
								item.last_byte);
						end
					end
				end
			end
			default: begin
				// Error codes are sticky until a new table starts
				nxt = base;
			end
		endcase
	end

endmodule

/* rtl/core/relocation_table_checker_core.sv */
// Top level of the relocation table checker: input stage, scan state, result
// register and image size register. Depends on rtc_pkg and rtc_step.
//
//  channel | signals                     | transaction
//  --------+-----------------------------+-------------------------------------
//  in      | in_valid, in_stall, in_data | one table byte with first/last marks
//  out     | out_valid, out_stall, out_data | status and counts after that byte
//  cfg     | cfg_we, cfg_data            | image_size write, no read-back
//
// One byte per cycle sustained while out_stall is low; each byte is registered in the input
// stage and then held in the result register until taken.
// The step logic (one 33-bit add, one subtract and compares) sits between them.
// arst_n clears the scan state, image_size and both valid flags.
// A held result stalls the input stage; the input stage stalls the input only
// when it is full and cannot move forward.
module relocation_table_checker_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  rtc_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output rtc_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_data
);
	import rtc_pkg::*;

	logic         valid_s1;
	in_t          item_s1;
	table_state_t state_q;
	table_state_t state_nxt;
	logic [31:0]  image_size_q;
	logic         out_valid_q;
	out_t         out_q;
	logic         advance;
	logic         in_take;

	// Result register free or being emptied this cycle
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	rtc_step u_step (
		.cur        (state_q),
		.item       (item_s1),
		.image_size (image_size_q),
		.nxt        (state_nxt)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= '0;
		end else if (cfg_we) begin
			image_size_q <= cfg_data;
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_data;
		end
	end

	// Scan state updates when the staged byte moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TableStateClear;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_q.status         <= state_nxt.scan_status;
			out_q.reloc_count    <= state_nxt.count_so_far;
			out_q.table_length   <= state_nxt.table_bytes;
			out_q.overlay_length <= state_nxt.trailing_bytes;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* test/relocation_table_checker_core_tb.sv */
// Testbench for relocation_table_checker_core: drives byte streams of relocation tables,
// predicts the status result of every byte in a local model and compares each result.
// Depends on rtc_pkg and the relocation_table_checker_core RTL.
module relocation_table_checker_core_tb;
	import rtc_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_t         in_data;
	logic        out_valid;
	logic        out_stall;
	out_t        out_data;
	logic        cfg_we;
	logic [31:0] cfg_data;

	// Local copy of the scan state and the image size register
	logic [31:0]            img_size;
	logic [31:0]            byte_pos;
	logic [OffsetWidth-1:0] cur_off;
	logic [OffsetWidth-1:0] prev_off;
	logic [31:0]            reloc_cnt;
	logic [31:0]            tbl_len;
	logic [31:0]            overlay_len;
	status_t                scan_st;

	out_t       expected_status_q[$];
	out_t       oldest_status;
	logic [7:0] table_q[$];
	int         fail_cnt;
	int         idle_pct;
	int         stall_pct;
	int         hold_req;
	int         hold_left;

	relocation_table_checker_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	// Clock, period 10
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Saturating 32-bit counter step
	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	// Alignment, image bound and truncation checks on the current offset
	function automatic status_t offset_status(input logic last);
		if (cur_off[0])
			return ST_MISALIGN;
		if ({1'b0, cur_off} + {1'b0, MinGap} > {2'b00, img_size})
			return ST_RANGE;
		if (last)
			return ST_TRUNC;
		return ST_SCAN;
	endfunction

	task automatic clear_scan();
		byte_pos    = '0;
		cur_off     = '0;
		prev_off    = '0;
		reloc_cnt   = '0;
		tbl_len     = '0;
		overlay_len = '0;
		scan_st     = ST_SCAN;
	endtask

	// Advance the local scan state by one byte and give the status it causes
	task automatic predict_status(input in_t item, output out_t res);
		if (item.first_byte)
			clear_scan();
		if (scan_st == ST_DONE) begin
			overlay_len = sat_inc(overlay_len);
		end else if (scan_st == ST_SCAN) begin
			if (byte_pos < 32'd4) begin
				// start offset, big-endian
				cur_off  = {cur_off[OffsetWidth-9:0], item.data_byte};
				byte_pos = byte_pos + 32'd1;
				if (byte_pos == 32'd4) begin
					cur_off[OffsetWidth-1] = 1'b0;
					reloc_cnt = 32'd1;
					prev_off  = cur_off;
					if (cur_off == '0)
						scan_st = ST_ZERO;
					else
						scan_st = offset_status(item.last_byte);
				end else if (item.last_byte) begin
					scan_st = ST_TRUNC;
				end
			end else begin
				byte_pos = sat_inc(byte_pos);
				if (item.data_byte == EndMarker) begin
					scan_st = ST_DONE;
					tbl_len = byte_pos;
				end else begin
					if (item.data_byte == SkipByte) begin
						cur_off = cur_off + SkipStep;
					end else if (item.data_byte[0]) begin
						scan_st = ST_ODD;
					end else begin
						cur_off = cur_off + {{(OffsetWidth-8){1'b0}}, item.data_byte};
						if (cur_off - prev_off < MinGap) begin
							scan_st = ST_OVERLAP;
						end else begin
							prev_off  = cur_off;
							reloc_cnt = sat_inc(reloc_cnt);
						end
					end
					if (scan_st == ST_SCAN)
						scan_st = offset_status(item.last_byte);
				end
			end
		end
		res.status         = scan_st;
		res.reloc_count    = reloc_cnt;
		res.table_length   = tbl_len;
		res.overlay_length = overlay_len;
	endtask

	// Offer one byte, wait for the transaction, then record its expected status
	task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
		in_t  item;
		out_t res;
		item.data_byte  = b;
		item.first_byte = first;
		item.last_byte  = last;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_status(item, res);
		expected_status_q.push_back(res);
	endtask

	// Send the bytes in table_q; last_byte marks the final one
	task automatic send_table(input bit mark_first);
		for (int i = 0; i < table_q.size(); i++)
			send_byte(table_q[i], mark_first && i == 0, i == table_q.size() - 1);
	endtask

	// Stop offering and wait until every expected status has arrived
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_status_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_image_size(input logic [31:0] v);
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		img_size = v;
	endtask

	// Build a random table: start offset, steps, usually an end marker and overlay
	task automatic build_table(input int n_steps);
		logic [31:0] off;
		int          r;
		table_q.delete();
		case ($urandom_range(9))
			0: off = '0;
			1: off = $urandom;
			2: off = img_size - $urandom_range(0, 700);
			default: off = ($urandom % ((img_size >> 2) | 32'd1)) << 1;
		endcase
		for (int i = 3; i >= 0; i--)
			table_q.push_back(off[i*8 +: 8]);
		repeat (n_steps) begin
			r = $urandom_range(99);
			if (r < 80)
				table_q.push_back(8'($urandom_range(2, 127) << 1));
			else if (r < 88)
				table_q.push_back(SkipByte);
			else if (r < 93)
				table_q.push_back(8'(($urandom_range(0, 127) << 1) | 1));
			else if (r < 97)
				table_q.push_back(8'd2);
			else
				table_q.push_back(8'($urandom_range(0, 127) << 1));
		end
		if ($urandom_range(99) < 85) begin
			table_q.push_back(EndMarker);
			repeat ($urandom_range(0, 3))
				table_q.push_back(8'($urandom));
		end
	endtask

	// Random phase: mostly well-formed tables, some raw noise bytes
	task automatic run_random_tables(input int n_items);
		int sent;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 10) begin
				repeat (6) begin
					send_byte(8'($urandom), $urandom_range(99) < 15, $urandom_range(99) < 15);
					sent++;
				end
			end else begin
				build_table($urandom_range(0, 12));
				send_table(1'b1);
				sent += table_q.size();
			end
		end
	endtask

	// No first_byte after reset: the block starts a table anyway; image_size still 0
	task automatic test_reset_state();
		table_q = '{8'h00, 8'h00, 8'h00, 8'h10, 8'h02};
		send_table(1'b0);
	endtask

	task automatic test_zero_start();
		write_image_size(32'h0000_1000);
		table_q = '{8'h00, 8'h00, 8'h00, 8'h00};
		send_table(1'b1);
	endtask

	// Skip, counted step, then a step that lands within 4 bytes of the last one
	task automatic test_steps_and_overlap();
		table_q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h04, 8'h02};
		send_table(1'b1);
	endtask

	// Counted step; then a new table in mid-table that starts misaligned; then an odd step
	task automatic test_odd_and_misalign();
		table_q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h03, 8'h04};
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h01, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h08, 1'b0, 1'b0);
		table_q = '{8'h00, 8'h00, 8'h01, 8'h01, 8'h04};
		send_table(1'b1);
		table_q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h03, 8'h04};
		send_table(1'b1);
	endtask

	// End marker with overlay bytes, end marker on the last byte, truncation
	task automatic test_end_and_truncation();
		table_q = '{8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'hFF, 8'h80};
		send_table(1'b1);
		table_q = '{8'h00, 8'h00, 8'h00, 8'h10, 8'h00};
		send_table(1'b1);
		table_q = '{8'h00, 8'h00, 8'h01};
		send_table(1'b1);
		table_q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h08};
		send_table(1'b1);
	endtask

	// Offsets at the top of a full 32-bit image
	task automatic test_image_extremes();
		write_image_size(32'hFFFF_FFFF);
		table_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'h02};
		send_table(1'b1);
		table_q = '{8'h7F, 8'hFF, 8'hFF, 8'hFA, 8'hFE, 8'h00};
		send_table(1'b1);
	endtask

	// Receiver holds off while the sender keeps offering, block fills up
	task automatic test_backpressure();
		write_image_size(32'h0001_0000);
		idle_pct = 0;
		hold_req = 60;
		table_q  = '{8'h00, 8'h00, 8'h10, 8'h00};
		repeat (16)
			table_q.push_back(8'($urandom_range(2, 127) << 1));
		table_q.push_back(EndMarker);
		send_table(1'b1);
		idle_pct = 23;
	endtask

	// Sender pauses mid-table until every result is in
	task automatic test_sender_pause();
		build_table(8);
		for (int i = 0; i < table_q.size(); i++) begin
			if (i == 5)
				wait_drained();
			send_byte(table_q[i], i == 0, i == table_q.size() - 1);
		end
	endtask

	task automatic test_random_phases();
		write_image_size(32'h0000_0000);
		run_random_tables(40);
		write_image_size(32'hFFFF_FFFF);
		run_random_tables(60);
		write_image_size(32'h0000_2000);
		run_random_tables(60);
		write_image_size($urandom);
		run_random_tables(60);
		// stretch with no idling on either side
		write_image_size(32'h0004_0000);
		idle_pct  = 0;
		stall_pct = 0;
		run_random_tables(60);
		idle_pct  = 23;
		stall_pct = 23;
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			fail_cnt++;
		end
	endfunction

	// Compare every result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_status_q.size() == 0) begin
				$error("result with no expectation waiting: status %0d", out_data.status);
				fail_cnt++;
			end else begin
				oldest_status = expected_status_q.pop_front();
				check_field("status", 32'(oldest_status.status), 32'(out_data.status));
				check_field("reloc_count", oldest_status.reloc_count, out_data.reloc_count);
				check_field("table_length", oldest_status.table_length, out_data.table_length);
				check_field("overlay_length", oldest_status.overlay_length,
					out_data.overlay_length);
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_data  = '0;
		fail_cnt  = 0;
		idle_pct  = 23;
		stall_pct = 23;
		hold_req  = 0;
		hold_left = 0;
		img_size  = '0;
		clear_scan();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_zero_start();
		test_steps_and_overlap();
		test_odd_and_misalign();
		test_end_and_truncation();
		test_image_extremes();
		test_backpressure();
		test_sender_pause();
		test_random_phases();

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_cnt == 0)
			$display("relocation_table_checker_core_tb passed");
		else
			$display("relocation_table_checker_core_tb failed");
		$finish;
	end

	// Timeout
	initial begin
		#3000000;
		$display("relocation_table_checker_core_tb failed");
		$finish;
	end

endmodule
